/* rtl/core/rgi_pkg.sv */
// shared types, constants and operand table for the rpc ground-to-image block
`default_nettype none
package rgi_pkg;

	// default word format
	localparam int WORD_BITS_DEF = 48;
	localparam int FRAC_BITS_DEF = 24;

	// store layout
	localparam int IDX_BITS   = 7;
	localparam int NUM_COEF   = 80;
	localparam int NUM_PARM   = 10;
	localparam int STORE_SIZE = NUM_COEF + NUM_PARM;
	localparam int NUM_TERMS  = 20;
	localparam int TERM_BITS  = 5;
	localparam int QDEPTH     = 2;

	// places of offsets and scales in the parameter bank
	localparam int PRM_LINE_OFF = 0;
	localparam int PRM_SAMP_OFF = 1;
	localparam int PRM_LAT_OFF  = 2;
	localparam int PRM_LON_OFF  = 3;
	localparam int PRM_HGT_OFF  = 4;
	localparam int PRM_LINE_SCL = 5;
	localparam int PRM_SAMP_SCL = 6;
	localparam int PRM_LAT_SCL  = 7;
	localparam int PRM_LON_SCL  = 8;
	localparam int PRM_HGT_SCL  = 9;

	// store slots of the constant denominator terms
	localparam logic [IDX_BITS-1:0] IDX_LDEN0 = IDX_BITS'(20);
	localparam logic [IDX_BITS-1:0] IDX_SDEN0 = IDX_BITS'(60);
	localparam logic [TERM_BITS-1:0] TERM_FIRST_PROD = TERM_BITS'(4);
	localparam logic [TERM_BITS-1:0] TERM_LAST = TERM_BITS'(NUM_TERMS - 1);

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_UNUSABLE = 2'd1,
		STAT_ZERO_DEN = 2'd2,
		STAT_SAT      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_EVAL       = 2'd0,
		CMD_LOAD_COEF  = 2'd1,
		CMD_LOAD_PARM  = 2'd2,
		CMD_LOAD_NONE  = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [IDX_BITS-1:0] idx;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_WRAP,
		ST_DIVX,
		ST_DIVY,
		ST_DIVZ,
		ST_TERM,
		ST_DOT,
		ST_CHKDEN,
		ST_MULL,
		ST_DIVL,
		ST_MULS,
		ST_DIVS,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		OP_X,
		OP_Y,
		OP_Z,
		OP_XY,
		OP_X2,
		OP_Y2,
		OP_Z2
	} opnd_t;

	typedef struct packed {
		opnd_t a;
		opnd_t b;
	} term_ops_t;

	// operands of each cubic product term
	function automatic term_ops_t term_ops(input logic [TERM_BITS-1:0] k);
		term_ops_t r;
		case (k)
			5'd4:    r = '{OP_X,  OP_Y};
			5'd5:    r = '{OP_X,  OP_Z};
			5'd6:    r = '{OP_Y,  OP_Z};
			5'd7:    r = '{OP_X,  OP_X};
			5'd8:    r = '{OP_Y,  OP_Y};
			5'd9:    r = '{OP_Z,  OP_Z};
			5'd10:   r = '{OP_XY, OP_Z};
			5'd11:   r = '{OP_X2, OP_X};
			5'd12:   r = '{OP_X,  OP_Y2};
			5'd13:   r = '{OP_X,  OP_Z2};
			5'd14:   r = '{OP_X2, OP_Y};
			5'd15:   r = '{OP_Y2, OP_Y};
			5'd16:   r = '{OP_Y,  OP_Z2};
			5'd17:   r = '{OP_X2, OP_Z};
			5'd18:   r = '{OP_Y2, OP_Z};
			5'd19:   r = '{OP_Z2, OP_Z};
			default: r = '{OP_X,  OP_X};
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/rgi_mul.sv */
// shared fixed-point multiplier built from four half-width partial products
`default_nettype none
module rgi_mul import rgi_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	output logic                 done,
	output logic [WORD_BITS-1:0] prod,
	output logic                 sat
);
	localparam int W = WORD_BITS;
	localparam int H = (W + 1) / 2;
	localparam int P = 4 * H;
	localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0]   xa_q, yb_q;
	logic           neg_q, busy_q, done_q, sat_q;
	logic [2:0]     step_q;
	logic [2*H-1:0] pp_q;
	logic [P-1:0]   acc_q, shifted, lim;
	logic [W-1:0]   prod_q;
	logic [H-1:0]   op_x, op_y;

	// half selection for the current partial product
	always_comb begin
		op_x = step_q[0] ? H'(xa_q >> H) : xa_q[H-1:0];
		op_y = step_q[1] ? H'(yb_q >> H) : yb_q[H-1:0];
		shifted = acc_q >> FRAC_BITS;
		lim = neg_q ? P'({1'b0, MAXW}) + P'(1) : P'({1'b0, MAXW});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial products, accumulate, round toward zero and saturate
	always_ff @(posedge clk) begin
		if (start) begin
			xa_q  <= a[W-1] ? W'(-a) : a;
			yb_q  <= b[W-1] ? W'(-b) : b;
			neg_q <= a[W-1] ^ b[W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q < 3'd4)
				pp_q <= op_x * op_y;
			if (step_q >= 3'd1 && step_q <= 3'd4)
				acc_q <= acc_q + (P'(pp_q) << (H * (int'(step_q[0] ^ 1'b1) +
					int'((step_q - 3'd1) >> 1))));
			if (step_q == 3'd5) begin
				if (shifted > lim) begin
					sat_q  <= 1'b1;
					prod_q <= neg_q ? MINW : MAXW;
				end else begin
					sat_q  <= 1'b0;
					prod_q <= neg_q ? W'(-shifted[W-1:0]) : shifted[W-1:0];
				end
			end
		end
	end

	assign done = done_q;
	assign prod = prod_q;
	assign sat  = sat_q;
endmodule
`default_nettype wire

/* rtl/core/rgi_div.sv */
// radix-2 restoring divider for fixed-point quotients
`default_nettype none
module rgi_div import rgi_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	output logic                 done,
	output logic [WORD_BITS-1:0] quo,
	output logic                 sat
);
	localparam int W  = WORD_BITS;
	localparam int L  = WORD_BITS + FRAC_BITS;
	localparam int CW = $clog2(L + 1);
	localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

	logic [L-1:0]  n_q, q_q, lim;
	logic [W-1:0]  d_q, r_q, quo_q;
	logic [W:0]    rr, diff;
	logic          ge, neg_q, busy_q, done_q, sat_q;
	logic [CW-1:0] cnt_q;

	// one quotient bit per cycle
	always_comb begin
		rr   = {r_q, n_q[L-1]};
		diff = rr - {1'b0, d_q};
		ge   = rr >= {1'b0, d_q};
		lim  = neg_q ? L'({1'b0, MAXW}) + L'(1) : L'({1'b0, MAXW});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(L)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= L'(a[W-1] ? W'(-a) : a) << FRAC_BITS;
			d_q   <= b[W-1] ? W'(-b) : b;
			neg_q <= a[W-1] ^ b[W-1];
			r_q   <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			if (cnt_q < CW'(L)) begin
				r_q <= ge ? diff[W-1:0] : rr[W-1:0];
				q_q <= {q_q[L-2:0], ge};
				n_q <= n_q << 1;
			end else if (d_q == '0) begin
				sat_q <= 1'b1;
				quo_q <= '0;
			end else if (q_q > lim) begin
				sat_q <= 1'b1;
				quo_q <= neg_q ? MINW : MAXW;
			end else begin
				sat_q <= 1'b0;
				quo_q <= neg_q ? W'(-q_q[W-1:0]) : q_q[W-1:0];
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign sat  = sat_q;
endmodule
`default_nettype wire

/* rtl/core/rgi_front.sv */
// input front end: classifies items and queues them for the back end
`default_nettype none
module rgi_front import rgi_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  logic [IDX_BITS-1:0]  word_index,
	input  logic [WORD_BITS-1:0] word_value,
	input  logic [WORD_BITS-1:0] longitude_deg,
	input  logic [WORD_BITS-1:0] latitude_deg,
	input  logic [WORD_BITS-1:0] height_m,
	output logic                 q_valid,
	input  logic                 q_pop,
	output cmd_t                 q_cmd,
	output logic [WORD_BITS-1:0] q_w0,
	output logic [WORD_BITS-1:0] q_w1,
	output logic [WORD_BITS-1:0] q_w2
);
	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t                 cmd_mem [QDEPTH];
	logic [WORD_BITS-1:0] w0_mem [QDEPTH];
	logic [WORD_BITS-1:0] w1_mem [QDEPTH];
	logic [WORD_BITS-1:0] w2_mem [QDEPTH];
	logic [PW-1:0]        wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]        count_q;
	logic                 push;
	cmd_t                 cls;

	// classify the incoming item
	always_comb begin
		cls.idx = word_index;
		if (!opcode)
			cls.kind = CMD_EVAL;
		else if (word_index < IDX_BITS'(NUM_COEF))
			cls.kind = CMD_LOAD_COEF;
		else if (word_index < IDX_BITS'(STORE_SIZE))
			cls.kind = CMD_LOAD_PARM;
		else
			cls.kind = CMD_LOAD_NONE;
	end

	assign in_ready = count_q < CW'(QDEPTH);
	assign push     = in_valid && in_ready;
	assign q_valid  = count_q != '0;

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (q_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			count_q <= count_q + CW'(push) - CW'(q_pop);
		end
	end

	// queue storage, word 0 holds the load value or the longitude
	always_ff @(posedge clk) begin
		if (push) begin
			cmd_mem[wr_ptr_q] <= cls;
			w0_mem[wr_ptr_q]  <= opcode ? word_value : longitude_deg;
			w1_mem[wr_ptr_q]  <= latitude_deg;
			w2_mem[wr_ptr_q]  <= height_m;
		end
	end

	assign q_cmd = cmd_mem[rd_ptr_q];
	assign q_w0  = w0_mem[rd_ptr_q];
	assign q_w1  = w1_mem[rd_ptr_q];
	assign q_w2  = w2_mem[rd_ptr_q];
endmodule
`default_nettype wire

/* rtl/core/rgi_back.sv */
// back end: parameter store, evaluation sequencer and result register
`default_nettype none
module rgi_back import rgi_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  cmd_t                 q_cmd,
	input  logic [WORD_BITS-1:0] q_w0,
	input  logic [WORD_BITS-1:0] q_w1,
	input  logic [WORD_BITS-1:0] q_w2,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [WORD_BITS-1:0] res_line,
	output logic [WORD_BITS-1:0] res_samp,
	output logic [1:0]           res_status
);
	localparam int W = WORD_BITS;
	localparam int AW = $clog2(NUM_COEF);
	localparam logic [W-1:0]   MAXW = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]   MINW = {1'b1, {(W-1){1'b0}}};
	localparam logic [2*W-1:0] MAXX = {{W{1'b0}}, MAXW};
	localparam logic [2*W-1:0] K1   = (2*W)'(1) << FRAC_BITS;
	localparam logic [2*W-1:0] K270 = (2*W)'(270) << FRAC_BITS;
	localparam logic [2*W-1:0] K360 = (2*W)'(360) << FRAC_BITS;
	localparam logic [W-1:0]   C1   = (K1 > MAXX) ? MAXW : K1[W-1:0];
	localparam logic [W-1:0]   C270 = (K270 > MAXX) ? MAXW : K270[W-1:0];
	localparam logic [W-1:0]   C360 = (K360 > MAXX) ? MAXW : K360[W-1:0];

	// saturating add and subtract, overflow flag in the top bit
	function automatic logic [W:0] add_sat(input logic [W-1:0] x, input logic [W-1:0] y);
		logic [W:0] s;
		s = {x[W-1], x} + {y[W-1], y};
		if (s[W] != s[W-1])
			return {1'b1, s[W] ? MINW : MAXW};
		return {1'b0, s[W-1:0]};
	endfunction

	function automatic logic [W:0] sub_sat(input logic [W-1:0] x, input logic [W-1:0] y);
		logic [W:0] s;
		s = {x[W-1], x} - {y[W-1], y};
		if (s[W] != s[W-1])
			return {1'b1, s[W] ? MINW : MAXW};
		return {1'b0, s[W-1:0]};
	endfunction

	state_t          state_q, state_d;
	logic            launch_q, launch_d1_q, res_valid_q, out_free, usable, adv;
	logic [W-1:0]    parm_q [NUM_PARM];
	logic [W-1:0]    den0_l_q, den0_s_q;
	logic            cvalid_q [NUM_COEF];
	logic [W-1:0]    coef_mem [NUM_COEF];
	logic [W-1:0]    crd_q;
	logic            crv_q;
	logic [AW-1:0]   raddr;
	logic [W-1:0]    coef;
	logic [W-1:0]    t_q [NUM_TERMS];
	logic [W-1:0]    dot_q [4];
	logic [W-1:0]    lon_q, lat_q, hgt_q, dl_q, dy_q, dz_q, acc_q, tmp_q;
	logic [W-1:0]    pl_q, ps_q, res_line_q, res_samp_q;
	status_t         pst_q, res_status_q;
	logic            sat_q;
	logic [TERM_BITS-1:0] kt_q;
	logic [1:0]      grp_q;
	term_ops_t       ops;
	logic [W-1:0]    opa, opb;
	logic            mul_start, mul_done, mul_sat, div_start, div_done, div_sat;
	logic [W-1:0]    mul_a, mul_b, mul_prod, div_a, div_b, div_quo;
	logic [W:0]      s_dl, s_dy, s_dz, s_wrap, s_acc, s_fin;
	logic            last_term, last_dot, den_zero;

	rgi_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_prod), .sat(mul_sat)
	);

	rgi_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .a(div_a), .b(div_b),
		.done(div_done), .quo(div_quo), .sat(div_sat)
	);

	// parameter check, arithmetic helpers
	always_comb begin
		usable = (den0_l_q != '0) && (den0_s_q != '0);
		for (int i = PRM_LINE_SCL; i <= PRM_HGT_SCL; i++)
			if (parm_q[i][W-1] || parm_q[i] == '0)
				usable = 1'b0;
		out_free  = !res_valid_q || res_ready;
		raddr     = AW'({grp_q, 4'b0000}) + AW'({grp_q, 2'b00}) + AW'(kt_q);
		coef      = crv_q ? crd_q : '0;
		s_dl      = sub_sat(lon_q, parm_q[PRM_LON_OFF]);
		s_dy      = sub_sat(lat_q, parm_q[PRM_LAT_OFF]);
		s_dz      = sub_sat(hgt_q, parm_q[PRM_HGT_OFF]);
		if ($signed(dl_q) < $signed(W'(-C270)))
			s_wrap = add_sat(dl_q, C360);
		else if ($signed(dl_q) > $signed(C270))
			s_wrap = sub_sat(dl_q, C360);
		else
			s_wrap = {1'b0, dl_q};
		s_acc     = add_sat(acc_q, mul_prod);
		s_fin     = add_sat((state_q == ST_DIVL) ? parm_q[PRM_LINE_OFF] : parm_q[PRM_SAMP_OFF],
			div_quo);
		last_term = kt_q == TERM_LAST;
		last_dot  = last_term && grp_q == 2'd3;
		den_zero  = dot_q[1] == '0 || dot_q[3] == '0;
		adv       = mul_done && (state_q == ST_TERM || state_q == ST_DOT);
		ops       = term_ops(kt_q);
	end

	// product term operands
	always_comb begin
		case (ops.a)
			OP_X:    opa = t_q[1];
			OP_Y:    opa = t_q[2];
			OP_Z:    opa = t_q[3];
			OP_XY:   opa = t_q[4];
			OP_X2:   opa = t_q[7];
			OP_Y2:   opa = t_q[8];
			OP_Z2:   opa = t_q[9];
			default: opa = t_q[1];
		endcase
		case (ops.b)
			OP_X:    opb = t_q[1];
			OP_Y:    opb = t_q[2];
			OP_Z:    opb = t_q[3];
			OP_XY:   opb = t_q[4];
			OP_X2:   opb = t_q[7];
			OP_Y2:   opb = t_q[8];
			OP_Z2:   opb = t_q[9];
			default: opb = t_q[1];
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (q_valid)
					state_d = (q_cmd.kind == CMD_EVAL && usable) ? ST_PREP : ST_EMIT;
			ST_PREP:   state_d = ST_WRAP;
			ST_WRAP:   state_d = ST_DIVX;
			ST_DIVX:   if (div_done) state_d = ST_DIVY;
			ST_DIVY:   if (div_done) state_d = ST_DIVZ;
			ST_DIVZ:   if (div_done) state_d = ST_TERM;
			ST_TERM:   if (mul_done && last_term) state_d = ST_DOT;
			ST_DOT:    if (mul_done && last_dot) state_d = ST_CHKDEN;
			ST_CHKDEN: state_d = den_zero ? ST_EMIT : ST_MULL;
			ST_MULL:   if (mul_done) state_d = ST_DIVL;
			ST_DIVL:   if (div_done) state_d = ST_MULS;
			ST_MULS:   if (mul_done) state_d = ST_DIVS;
			ST_DIVS:   if (div_done) state_d = ST_EMIT;
			ST_EMIT:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// unit launches and operand selection
	always_comb begin
		q_pop     = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_a     = '0;
		div_b     = '0;
		case (state_q)
			ST_IDLE: q_pop = q_valid;
			ST_DIVX: begin
				div_start = launch_q;
				div_a     = dl_q;
				div_b     = parm_q[PRM_LON_SCL];
			end
			ST_DIVY: begin
				div_start = launch_q;
				div_a     = dy_q;
				div_b     = parm_q[PRM_LAT_SCL];
			end
			ST_DIVZ: begin
				div_start = launch_q;
				div_a     = dz_q;
				div_b     = parm_q[PRM_HGT_SCL];
			end
			ST_TERM: begin
				mul_start = launch_q;
				mul_a     = opa;
				mul_b     = opb;
			end
			ST_DOT: begin
				mul_start = launch_d1_q;
				mul_a     = coef;
				mul_b     = t_q[kt_q];
			end
			ST_MULL: begin
				mul_start = launch_q;
				mul_a     = parm_q[PRM_LINE_SCL];
				mul_b     = dot_q[0];
			end
			ST_DIVL: begin
				div_start = launch_q;
				div_a     = tmp_q;
				div_b     = dot_q[1];
			end
			ST_MULS: begin
				mul_start = launch_q;
				mul_a     = parm_q[PRM_SAMP_SCL];
				mul_b     = dot_q[2];
			end
			ST_DIVS: begin
				div_start = launch_q;
				div_a     = tmp_q;
				div_b     = dot_q[3];
			end
			default: ;
		endcase
	end

	// control state, store valid bits, offsets and scales, result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launch_q    <= 1'b0;
			launch_d1_q <= 1'b0;
			res_valid_q <= 1'b0;
			den0_l_q    <= '0;
			den0_s_q    <= '0;
			for (int i = 0; i < NUM_PARM; i++)
				parm_q[i] <= '0;
			for (int i = 0; i < NUM_COEF; i++)
				cvalid_q[i] <= 1'b0;
		end else begin
			state_q     <= state_d;
			launch_q    <= (state_d != state_q) || adv;
			launch_d1_q <= launch_q;
			if (state_q == ST_EMIT && out_free)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
			if (q_pop) begin
				case (q_cmd.kind)
					CMD_LOAD_COEF: begin
						cvalid_q[q_cmd.idx[AW-1:0]] <= 1'b1;
						if (q_cmd.idx == IDX_LDEN0)
							den0_l_q <= q_w0;
						if (q_cmd.idx == IDX_SDEN0)
							den0_s_q <= q_w0;
					end
					CMD_LOAD_PARM:
						parm_q[4'(q_cmd.idx - IDX_BITS'(NUM_COEF))] <= q_w0;
					default: ;
				endcase
			end
		end
	end

	// coefficient memory, registered read
	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.kind == CMD_LOAD_COEF)
			coef_mem[q_cmd.idx[AW-1:0]] <= q_w0;
		crd_q <= coef_mem[raddr];
		crv_q <= cvalid_q[raddr];
	end

	// evaluation datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				lon_q <= q_w0;
				lat_q <= q_w1;
				hgt_q <= q_w2;
				sat_q <= 1'b0;
				pl_q  <= '0;
				ps_q  <= '0;
				pst_q <= (q_cmd.kind == CMD_EVAL) ? STAT_UNUSABLE : STAT_OK;
			end
			ST_PREP: begin
				dl_q   <= s_dl[W-1:0];
				dy_q   <= s_dy[W-1:0];
				dz_q   <= s_dz[W-1:0];
				sat_q  <= sat_q | s_dl[W] | s_dy[W] | s_dz[W];
				t_q[0] <= C1;
			end
			ST_WRAP: begin
				dl_q  <= s_wrap[W-1:0];
				sat_q <= sat_q | s_wrap[W];
			end
			ST_DIVX, ST_DIVY, ST_DIVZ: begin
				if (div_done) begin
					sat_q <= sat_q | div_sat;
					if (state_q == ST_DIVX)
						t_q[1] <= div_quo;
					else if (state_q == ST_DIVY)
						t_q[2] <= div_quo;
					else
						t_q[3] <= div_quo;
				end
				kt_q <= TERM_FIRST_PROD;
			end
			ST_TERM: begin
				if (mul_done) begin
					t_q[kt_q] <= mul_prod;
					sat_q     <= sat_q | mul_sat;
					kt_q      <= last_term ? '0 : kt_q + TERM_BITS'(1);
				end
				grp_q <= '0;
				acc_q <= '0;
			end
			ST_DOT: begin
				if (mul_done) begin
					sat_q <= sat_q | mul_sat | s_acc[W];
					if (last_term) begin
						dot_q[grp_q] <= s_acc[W-1:0];
						acc_q        <= '0;
						kt_q         <= '0;
						grp_q        <= grp_q + 2'd1;
					end else begin
						acc_q <= s_acc[W-1:0];
						kt_q  <= kt_q + TERM_BITS'(1);
					end
				end
			end
			ST_CHKDEN: pst_q <= STAT_ZERO_DEN;
			ST_MULL, ST_MULS: begin
				if (mul_done) begin
					tmp_q <= mul_prod;
					sat_q <= sat_q | mul_sat;
				end
			end
			ST_DIVL: begin
				if (div_done) begin
					pl_q  <= s_fin[W-1:0];
					sat_q <= sat_q | div_sat | s_fin[W];
				end
			end
			ST_DIVS: begin
				if (div_done) begin
					ps_q  <= s_fin[W-1:0];
					pst_q <= (sat_q | div_sat | s_fin[W]) ? STAT_SAT : STAT_OK;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					res_line_q   <= pl_q;
					res_samp_q   <= ps_q;
					res_status_q <= pst_q;
				end
			end
			default: ;
		endcase
	end

	assign res_valid  = res_valid_q;
	assign res_line   = res_line_q;
	assign res_samp   = res_samp_q;
	assign res_status = res_status_q;
endmodule
`default_nettype wire

/* rtl/core/rpc_ground_to_image_unit.sv */
// top level of the rpc ground-to-image projection block
//
// Input stream: s_tuser is the opcode (1 = load one store word, 0 = evaluate
// a ground point); s_tdata carries word index, load value, longitude,
// latitude and height. Output stream: one transfer per input transfer,
// m_tdata carries line and sample, m_tuser the status code.
// Items pass a two-entry queue from the front end to the back end, which
// handles one item at a time in arrival order, so loads and evaluations
// never overtake each other.
// Loads only update the store. An evaluation runs five divisions in the
// one-bit-per-cycle divider, 18 products in the shared four-pass multiplier,
// and the 80-product coefficient walk, where each product starts only after
// the registered coefficient memory read.
// Items with unusable parameters skip the arithmetic and go to the output.
// Reset clears the store to zero, empties the queue and drops any result.
// A finished result waits in the output register while the back end already
// takes the next item; a further result waits until m_tready frees it, and
// s_tready falls once the queue is full.
`default_nettype none
module rpc_ground_to_image_unit import rgi_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// word_index, word_value, longitude_deg, latitude_deg, height_m
	input  logic [((IDX_BITS + 4 * WORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// opcode
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// line_coord, sample_coord
	output logic [((2 * WORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// status
	output logic [1:0] m_tuser
);
	localparam int W  = WORD_BITS;
	localparam int MW = ((2 * WORD_BITS + 7) / 8) * 8;

	logic         q_valid, q_pop;
	cmd_t         q_cmd;
	logic [W-1:0] q_w0, q_w1, q_w2, res_line, res_samp;

	rgi_front #(.WORD_BITS(WORD_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.opcode(s_tuser),
		.word_index(s_tdata[IDX_BITS-1:0]),
		.word_value(s_tdata[IDX_BITS +: W]),
		.longitude_deg(s_tdata[IDX_BITS + W +: W]),
		.latitude_deg(s_tdata[IDX_BITS + 2 * W +: W]),
		.height_m(s_tdata[IDX_BITS + 3 * W +: W]),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_cmd(q_cmd),
		.q_w0(q_w0),
		.q_w1(q_w1),
		.q_w2(q_w2)
	);

	rgi_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_cmd(q_cmd),
		.q_w0(q_w0),
		.q_w1(q_w1),
		.q_w2(q_w2),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res_line(res_line),
		.res_samp(res_samp),
		.res_status(m_tuser)
	);

	// pack the result, zero fill to whole bytes
	assign m_tdata = MW'({res_samp, res_line});
endmodule
`default_nettype wire

/* verif/rpc_ground_to_image_unit_tb.sv */
// self-checking testbench for the rpc ground-to-image block: store loads and point projection
`timescale 1ns / 100ps
`default_nettype none
module rpc_ground_to_image_unit_tb;
	import rgi_pkg::*;

	localparam int WB = WORD_BITS_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int CLK_PERIOD = 12;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int ITEM_TARGET = 1400;

	// opcode carried on s_tuser
	localparam logic OPC_EVAL = 1'b0;
	localparam logic OPC_LOAD = 1'b1;

	// store slots of offsets and scales
	localparam int IX_LINE_OFF = NUM_COEF + PRM_LINE_OFF;
	localparam int IX_SAMP_OFF = NUM_COEF + PRM_SAMP_OFF;
	localparam int IX_LAT_OFF  = NUM_COEF + PRM_LAT_OFF;
	localparam int IX_LON_OFF  = NUM_COEF + PRM_LON_OFF;
	localparam int IX_HGT_OFF  = NUM_COEF + PRM_HGT_OFF;
	localparam int IX_LINE_SCL = NUM_COEF + PRM_LINE_SCL;
	localparam int IX_SAMP_SCL = NUM_COEF + PRM_SAMP_SCL;
	localparam int IX_LAT_SCL  = NUM_COEF + PRM_LAT_SCL;
	localparam int IX_LON_SCL  = NUM_COEF + PRM_LON_SCL;
	localparam int IX_HGT_SCL  = NUM_COEF + PRM_HGT_SCL;
	localparam int IX_LDEN0    = 20;
	localparam int IX_SDEN0    = 60;

	typedef logic signed [WB-1:0] word_t;
	localparam word_t WMAX = {1'b0, {(WB-1){1'b1}}};
	localparam word_t WMIN = {1'b1, {(WB-1){1'b0}}};
	localparam word_t ONE  = word_t'(64'd1 << FB);

	typedef struct {
		logic                opc;
		logic [IDX_BITS-1:0] idx;
		word_t               value;
		word_t               lon;
		word_t               lat;
		word_t               hgt;
	} item_t;

	typedef struct {
		word_t   line;
		word_t   samp;
		status_t st;
	} coord_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [199:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [95:0] m_tdata;
	logic [1:0] m_tuser;

	word_t  image_store [STORE_SIZE];
	coord_t coord_q [$];
	int     items_sent;
	int     fail_count;
	int     cycle_count;
	bit     idle_en;
	int     hold_left;

	rpc_ground_to_image_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// fixed-point helpers, saturating like the block

	function automatic logic [63:0] mag(word_t v);
		longint sv;
		sv = v;
		return sv < 0 ? 64'(-sv) : 64'(sv);
	endfunction

	function automatic word_t pack_w(bit neg, logic [63:0] m, inout bit sat);
		if (!neg) begin
			if (m > 64'(WMAX)) begin
				sat = 1'b1;
				m = 64'(WMAX);
			end
			return word_t'(m);
		end
		if (m > 64'(WMAX) + 64'd1) begin
			sat = 1'b1;
			m = 64'(WMAX) + 64'd1;
		end
		return word_t'(~m + 64'd1);
	endfunction

	function automatic word_t add_sm(bit na, logic [63:0] ma, bit nb, logic [63:0] mb,
			inout bit sat);
		logic [64:0] s;
		if (na == nb) begin
			s = {1'b0, ma} + {1'b0, mb};
			if (s[64]) begin
				sat = 1'b1;
				return pack_w(na, '1, sat);
			end
			return pack_w(na, s[63:0], sat);
		end
		if (ma >= mb)
			return pack_w(na, ma - mb, sat);
		return pack_w(nb, mb - ma, sat);
	endfunction

	function automatic word_t sat_add(word_t a, word_t b, inout bit sat);
		return add_sm(a < 0, mag(a), b < 0, mag(b), sat);
	endfunction

	function automatic word_t sat_sub(word_t a, word_t b, inout bit sat);
		return add_sm(a < 0, mag(a), !(b < 0), mag(b), sat);
	endfunction

	function automatic word_t sat_mul(word_t a, word_t b, inout bit sat);
		logic [127:0] p;
		bit neg;
		p = {64'd0, mag(a)} * {64'd0, mag(b)};
		p = p >> FB;
		neg = (a < 0) != (b < 0);
		if (p[127:64] != 0) begin
			sat = 1'b1;
			return pack_w(neg, '1, sat);
		end
		return pack_w(neg, p[63:0], sat);
	endfunction

	function automatic word_t sat_div(word_t a, word_t b, inout bit sat);
		logic [127:0] q;
		logic [63:0] d;
		bit neg;
		d = mag(b);
		neg = (a < 0) != (b < 0);
		if (d == 0) begin
			sat = 1'b1;
			return '0;
		end
		q = ({64'd0, mag(a)} << FB) / {64'd0, d};
		if (q[127:64] != 0) begin
			sat = 1'b1;
			return pack_w(neg, '1, sat);
		end
		return pack_w(neg, q[63:0], sat);
	endfunction

	// projection of one ground point with the current store
	function automatic coord_t project_point(word_t lon, word_t lat, word_t hgt);
		coord_t r;
		bit sat;
		word_t x, y, z, dl, x2, y2, z2, c270, c360;
		word_t lnum, lden, snum, sden;
		word_t t [NUM_TERMS];
		word_t dots [4];
		r = '{line: '0, samp: '0, st: STAT_OK};
		sat = 1'b0;
		for (int k = IX_LINE_SCL; k <= IX_HGT_SCL; k++)
			if (image_store[k] <= 0) begin
				r.st = STAT_UNUSABLE;
				return r;
			end
		if (image_store[IX_LDEN0] == 0 || image_store[IX_SDEN0] == 0) begin
			r.st = STAT_UNUSABLE;
			return r;
		end
		c270 = word_t'(64'd270 << FB);
		c360 = word_t'(64'd360 << FB);
		// longitude difference wrapped into +-270 degrees
		dl = sat_sub(lon, image_store[IX_LON_OFF], sat);
		if (dl < -c270)
			dl = sat_add(dl, c360, sat);
		else if (dl > c270)
			dl = sat_sub(dl, c360, sat);
		x = sat_div(dl, image_store[IX_LON_SCL], sat);
		y = sat_div(sat_sub(lat, image_store[IX_LAT_OFF], sat), image_store[IX_LAT_SCL], sat);
		z = sat_div(sat_sub(hgt, image_store[IX_HGT_OFF], sat), image_store[IX_HGT_SCL], sat);
		// cubic terms
		x2 = sat_mul(x, x, sat);
		y2 = sat_mul(y, y, sat);
		z2 = sat_mul(z, z, sat);
		t[0] = ONE;
		t[1] = x;
		t[2] = y;
		t[3] = z;
		t[4] = sat_mul(x, y, sat);
		t[5] = sat_mul(x, z, sat);
		t[6] = sat_mul(y, z, sat);
		t[7] = x2;
		t[8] = y2;
		t[9] = z2;
		t[10] = sat_mul(t[4], z, sat);
		t[11] = sat_mul(x2, x, sat);
		t[12] = sat_mul(x, y2, sat);
		t[13] = sat_mul(x, z2, sat);
		t[14] = sat_mul(x2, y, sat);
		t[15] = sat_mul(y2, y, sat);
		t[16] = sat_mul(y, z2, sat);
		t[17] = sat_mul(x2, z, sat);
		t[18] = sat_mul(y2, z, sat);
		t[19] = sat_mul(z2, z, sat);
		// four dot products over the coefficient blocks
		for (int p = 0; p < 4; p++) begin
			dots[p] = '0;
			for (int k = 0; k < NUM_TERMS; k++)
				dots[p] = sat_add(dots[p],
					sat_mul(image_store[p * NUM_TERMS + k], t[k], sat), sat);
		end
		lnum = dots[0];
		lden = dots[1];
		snum = dots[2];
		sden = dots[3];
		if (lden == 0 || sden == 0) begin
			r.st = STAT_ZERO_DEN;
			return r;
		end
		r.line = sat_add(image_store[IX_LINE_OFF],
			sat_div(sat_mul(image_store[IX_LINE_SCL], lnum, sat), lden, sat), sat);
		r.samp = sat_add(image_store[IX_SAMP_OFF],
			sat_div(sat_mul(image_store[IX_SAMP_SCL], snum, sat), sden, sat), sat);
		r.st = sat ? STAT_SAT : STAT_OK;
		return r;
	endfunction

	// applies an accepted item and queues its coordinates
	task automatic record_item(input item_t it);
		coord_t r;
		if (it.opc == OPC_LOAD) begin
			if (it.idx < STORE_SIZE)
				image_store[it.idx] = it.value;
			r = '{line: '0, samp: '0, st: STAT_OK};
		end else
			r = project_point(it.lon, it.lat, it.hgt);
		coord_q.push_back(r);
	endtask

	function automatic word_t rand_word();
		return word_t'({$urandom, $urandom});
	endfunction

	// one input transfer, with random gaps before it while idle_en is set
	task automatic send_item(input item_t it);
		@(negedge clk);
		if (idle_en)
			while ($urandom_range(99) < 35) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		s_tvalid <= 1'b1;
		s_tuser <= it.opc;
		s_tdata <= {1'b0, it.hgt, it.lat, it.lon, it.value, it.idx};
		do @(posedge clk); while (!s_tready);
		record_item(it);
		items_sent++;
	endtask

	task automatic load_word(input int idx, input word_t val);
		item_t it;
		it = '{opc: OPC_LOAD, idx: IDX_BITS'(idx), value: val,
			lon: rand_word(), lat: rand_word(), hgt: rand_word()};
		send_item(it);
	endtask

	task automatic eval_point(input word_t lon, input word_t lat, input word_t hgt);
		item_t it;
		it = '{opc: OPC_EVAL, idx: IDX_BITS'($urandom), value: rand_word(),
			lon: lon, lat: lat, hgt: hgt};
		send_item(it);
	endtask

	// stop offering and wait for every queued result
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (coord_q.size() != 0)
			@(posedge clk);
	endtask

	// plain model: line = 1 / (1 - x), sample = 1, unit scales, zero offsets
	task automatic load_plain_model();
		for (int k = 0; k < STORE_SIZE; k++)
			load_word(k, (k == 0 || k == 20 || k == 40 || k == 60 || k >= IX_LINE_SCL)
				? ONE : (k == 21 ? -ONE : word_t'(0)));
	endtask

	// well-conditioned random model, with a few noise loads past the store
	task automatic load_random_model();
		word_t v;
		for (int k = 0; k < STORE_SIZE; k++) begin
			if ($urandom_range(19) == 0)
				load_word($urandom_range(STORE_SIZE, 127), rand_word());
			if (k == IX_LDEN0 || k == IX_SDEN0)
				v = ONE + word_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
			else if ((k > IX_LDEN0 && k < 40) || (k > IX_SDEN0 && k < NUM_COEF))
				v = word_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
			else if (k < NUM_COEF)
				v = word_t'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
			else if (k == IX_LINE_SCL || k == IX_SAMP_SCL)
				v = word_t'(longint'($urandom_range(1, 10000)) << FB);
			else if (k >= IX_LINE_SCL)
				v = word_t'(longint'($urandom_range(1 << 20, 1 << 31)));
			else
				v = word_t'(longint'($signed($urandom_range(0, 400)) - 200) << FB)
					+ word_t'($urandom_range(0, (1 << FB) - 1));
			load_word(k, v);
		end
	endtask

	function automatic word_t near_offset(int off_ix, int scl_ix);
		longint r;
		r = longint'($signed($urandom_range(0, 4096))) - 2048;
		return word_t'(longint'(image_store[off_ix]) + r * longint'(image_store[scl_ix]) / 1024);
	endfunction

	task automatic eval_random_point();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			eval_point(rand_word(), rand_word(), rand_word());
		else if (pick < 16)
			eval_point(image_store[IX_LON_OFF]
				+ word_t'(($urandom_range(1) ? 300 : -300) * longint'(ONE))
				+ word_t'($urandom_range(0, 1 << 24)),
				near_offset(IX_LAT_OFF, IX_LAT_SCL), near_offset(IX_HGT_OFF, IX_HGT_SCL));
		else
			eval_point(near_offset(IX_LON_OFF, IX_LON_SCL),
				near_offset(IX_LAT_OFF, IX_LAT_SCL), near_offset(IX_HGT_OFF, IX_HGT_SCL));
	endtask

	// all-zero store after reset, and loads past the last slot
	task automatic test_reset_store();
		eval_point('0, '0, '0);
		eval_point(WMAX, WMIN, WMAX);
		load_word(STORE_SIZE, WMAX);
		load_word(127, WMIN);
		eval_point(WMIN, WMAX, WMIN);
	endtask

	// zero denominator, longitude wrap and saturation on the plain model
	task automatic test_plain_model();
		load_plain_model();
		eval_point(ONE, '0, '0);
		eval_point(ONE >>> 1, '0, '0);
		eval_point(word_t'(300 * longint'(ONE)), '0, '0);
		eval_point(word_t'(-300 * longint'(ONE)), WMAX, WMIN);
		eval_point(WMAX, WMIN, WMAX);
		eval_point(WMIN, '0, '0);
		load_word(IX_LINE_SCL, WMAX);
		eval_point(ONE >>> 2, '0, '0);
		drain();
	endtask

	// each scale not positive, and each constant denominator term zero
	task automatic test_unusable_params();
		word_t keep;
		load_random_model();
		for (int k = IX_LINE_SCL; k <= IX_HGT_SCL; k++) begin
			keep = image_store[k];
			load_word(k, '0);
			eval_random_point();
			load_word(k, ($urandom_range(1)) ? WMIN : -ONE);
			eval_random_point();
			load_word(k, keep);
		end
		keep = image_store[IX_LDEN0];
		load_word(IX_LDEN0, '0);
		eval_random_point();
		load_word(IX_LDEN0, keep);
		keep = image_store[IX_SDEN0];
		load_word(IX_SDEN0, '0);
		eval_random_point();
		load_word(IX_SDEN0, keep);
		eval_random_point();
		drain();
	endtask

	// long receiver hold-off while items keep coming, then a full drain
	task automatic test_backpressure();
		hold_left = 4000;
		for (int i = 0; i < 6; i++)
			eval_random_point();
		for (int i = 0; i < 4; i++)
			load_word($urandom_range(0, 127), rand_word());
		drain();
	endtask

	// random models with random points until the item budget is spent
	task automatic test_random_models();
		int round;
		round = 0;
		while (items_sent < ITEM_TARGET) begin
			idle_en = (round != 2);
			load_random_model();
			for (int i = 0; i < 20; i++) begin
				if ($urandom_range(9) == 0)
					load_word($urandom_range(0, NUM_COEF - 1),
						word_t'($signed($urandom_range(0, 1 << 26)) - (1 << 25)));
				eval_random_point();
			end
			if ($urandom_range(3) == 0)
				drain();
			round++;
		end
		idle_en = 1'b1;
		drain();
	endtask

	// receiver ready, with random stalls and a commanded hold-off
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else
				m_tready <= idle_en ? ($urandom_range(99) >= 35) : 1'b1;
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		coord_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (coord_q.size() == 0) begin
				$error("result transfer with no expectation waiting");
				fail_count++;
			end else begin
				want = coord_q.pop_front();
				if (word_t'(m_tdata[WB-1:0]) !== want.line) begin
					$error("line_coord expected %0d actual %0d", want.line,
						word_t'(m_tdata[WB-1:0]));
					fail_count++;
				end
				if (word_t'(m_tdata[2*WB-1:WB]) !== want.samp) begin
					$error("sample_coord expected %0d actual %0d", want.samp,
						word_t'(m_tdata[2*WB-1:WB]));
					fail_count++;
				end
				if (m_tuser !== want.st) begin
					$error("status expected %0d actual %0d", want.st, m_tuser);
					fail_count++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		items_sent = 0;
		fail_count = 0;
		cycle_count = 0;
		idle_en = 1'b1;
		hold_left = 0;
		for (int k = 0; k < STORE_SIZE; k++)
			image_store[k] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_store();
		test_plain_model();
		test_unusable_params();
		test_backpressure();
		test_random_models();

		repeat (200) @(posedge clk);
		if (coord_q.size() != 0) begin
			$error("%0d expected results never arrived", coord_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire

/* rpc_ground_to_image_unit.f */
rtl/core/rgi_pkg.sv
rtl/core/rgi_mul.sv
rtl/core/rgi_div.sv
rtl/core/rgi_front.sv
rtl/core/rgi_back.sv
rtl/core/rpc_ground_to_image_unit.sv
verif/rpc_ground_to_image_unit_tb.sv
